// ----- rtl/raabb_pkg.sv -----
package raabb_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 3;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  // box register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_MIN_X = 3'd0,
    CFG_BOX_MIN_Y = 3'd1,
    CFG_BOX_MIN_Z = 3'd2,
    CFG_BOX_MAX_X = 3'd3,
    CFG_BOX_MAX_Y = 3'd4,
    CFG_BOX_MAX_Z = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] origin_x;
    logic signed [DATA_W-1:0] origin_y;
    logic signed [DATA_W-1:0] origin_z;
    logic signed [DATA_W-1:0] dir_x;
    logic signed [DATA_W-1:0] dir_y;
    logic signed [DATA_W-1:0] dir_z;
  } req_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] near_distance;
  } rsp_t;

  // cycles from the accepting edge to the edge that samples the result strobe
  function automatic int latency(input int frac_bits);
    return 2 * frac_bits + 6;
  endfunction

endpackage

// ----- rtl/raabb_recip.sv -----
// pipelined restoring divider: quot = 2^(2*FRAC_BITS) / mag, one quotient bit per stage
module raabb_recip #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic [31:0]              mag,
  output logic [2*FRAC_BITS:0]     quot
);

  localparam int NS = 2 * FRAC_BITS + 1;
  localparam int QW = NS;

  logic [32:0]   rem_q [NS];
  logic [QW-1:0] quo_q [NS];
  logic [31:0]   mag_q [NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [32:0]   rem_in;
    logic [32:0]   shifted;
    logic [32:0]   diff;
    logic [31:0]   m_in;
    logic [QW-1:0] q_in;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign q_in   = '0;
      assign m_in   = mag;
    end else begin : g_rest
      assign rem_in = rem_q[k-1];
      assign q_in   = quo_q[k-1];
      assign m_in   = mag_q[k-1];
    end

    // the dividend has a single set bit, consumed by the first stage
    assign shifted = {rem_in[31:0], 1'(k == 0)};
    assign diff    = shifted - {1'b0, m_in};
    assign ge      = !diff[32];

    always_ff @(posedge clk) begin
      rem_q[k] <= ge ? diff : shifted;
      quo_q[k] <= {q_in[QW-2:0], ge};
    end

    if (k < NS - 1) begin : g_mag
      always_ff @(posedge clk) begin
        mag_q[k] <= m_in;
      end
    end
  end

  assign quot = quo_q[NS-1];

endmodule

// ----- rtl/ray_aabb_slab_test.sv -----
// channel   | ports                                  | handshake
// ----------+----------------------------------------+-------------------------------
// request   | start, busy, req (req_t)               | taken when start && !busy
// result    | done, rsp (rsp_t)                      | one-cycle strobe, no back-pressure
// config    | cfg_we, cfg_index, cfg_data            | write when cfg_we, no wait
//
// one request per cycle, sustained; busy is never raised
// result strobe follows input reg, divider, p1, p2, p3 and done reg (Q16.16 by default);
// the depth is set by the reciprocal divider, one quotient bit per stage
// rst (synchronous) clears the valid bits and the box registers; in-flight requests are dropped
// the pipeline never stalls: every stage advances every cycle
module ray_aabb_slab_test
  import raabb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 req,
  output logic                 done,
  output rsp_t                 rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  localparam int NS = 2 * FRAC_BITS + 1;  // divider stages
  localparam int QW = NS;                 // quotient width

  // side data that travels alongside the divider
  typedef struct packed {
    logic signed [DATA_W-1:0] ox;
    logic signed [DATA_W-1:0] oy;
    logic signed [DATA_W-1:0] oz;
    logic [2:0]               dneg;
    logic [2:0]               dzero;
  } side_t;

  // box registers
  logic signed [DATA_W-1:0] box_lo [3];
  logic signed [DATA_W-1:0] box_hi [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        box_lo[i] <= '0;
        box_hi[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BOX_MIN_X: box_lo[0] <= cfg_data;
        CFG_BOX_MIN_Y: box_lo[1] <= cfg_data;
        CFG_BOX_MIN_Z: box_lo[2] <= cfg_data;
        CFG_BOX_MAX_X: box_hi[0] <= cfg_data;
        CFG_BOX_MAX_Y: box_hi[1] <= cfg_data;
        CFG_BOX_MAX_Z: box_hi[2] <= cfg_data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  assign busy = 1'b0;

  // input register
  req_t a_req;
  logic a_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_req <= req;
  end

  // direction magnitudes feed three divider pipes
  logic signed [DATA_W-1:0] a_dir [3];
  logic [QW-1:0]            quot  [3];

  assign a_dir[0] = a_req.dir_x;
  assign a_dir[1] = a_req.dir_y;
  assign a_dir[2] = a_req.dir_z;

  for (genvar a = 0; a < 3; a++) begin : g_div
    logic [31:0] mag;
    assign mag = a_dir[a][31] ? 32'(-a_dir[a]) : 32'(a_dir[a]);

    raabb_recip #(
      .FRAC_BITS (FRAC_BITS)
    ) u_recip (
      .clk  (clk),
      .mag  (mag),
      .quot (quot[a])
    );
  end

  // side pipe and valid bits matched to the divider depth
  side_t       side_q [NS];
  logic [NS-1:0] dv_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_q <= '0;
    end else begin
      dv_q <= {dv_q[NS-2:0], a_vld};
    end
  end

  always_ff @(posedge clk) begin
    side_q[0].ox    <= a_req.origin_x;
    side_q[0].oy    <= a_req.origin_y;
    side_q[0].oz    <= a_req.origin_z;
    side_q[0].dneg  <= {a_dir[2][31], a_dir[1][31], a_dir[0][31]};
    side_q[0].dzero <= {a_dir[2] == '0, a_dir[1] == '0, a_dir[0] == '0};
    for (int k = 1; k < NS; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  logic signed [DATA_W-1:0] s_org [3];
  assign s_org[0] = side_q[NS-1].ox;
  assign s_org[1] = side_q[NS-1].oy;
  assign s_org[2] = side_q[NS-1].oz;

  // p1: saturated signed reciprocal, plane distances, swap
  // p2: products
  // p3: floor shift and saturate
  logic                     p1_vld, p2_vld, p3_vld;
  logic signed [DATA_W-1:0] p1_rec  [3];
  logic signed [DATA_W:0]   p1_din  [3];
  logic signed [DATA_W:0]   p1_dout [3];
  logic [2:0]               p1_skip, p2_skip, p3_skip;
  logic [2:0]               p1_okax, p2_okax, p3_okax;
  logic signed [64:0]       p2_pin  [3];
  logic signed [64:0]       p2_pout [3];
  logic signed [DATA_W-1:0] p3_tin  [3];
  logic signed [DATA_W-1:0] p3_tout [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic [63:0]              q64;
    logic                     neg;
    logic                     swap;
    logic signed [DATA_W-1:0] rec;
    logic signed [DATA_W:0]   dlo;
    logic signed [DATA_W:0]   dhi;
    logic                     inslab;
    logic signed [64:0]       sh_in;
    logic signed [64:0]       sh_out;

    assign q64  = 64'(quot[a]);
    assign neg  = side_q[NS-1].dneg[a];
    // a quotient truncated to zero never swaps
    assign swap = neg && (q64 != '0);

    always_comb begin
      if (neg) begin
        rec = (q64 > 64'h8000_0000) ? S32_MIN : DATA_W'(64'd0 - q64);
      end else begin
        rec = (q64 > 64'h7fff_ffff) ? S32_MAX : DATA_W'(q64);
      end
    end

    assign dlo    = {box_lo[a][31], box_lo[a]} - {s_org[a][31], s_org[a]};
    assign dhi    = {box_hi[a][31], box_hi[a]} - {s_org[a][31], s_org[a]};
    assign inslab = (s_org[a] >= box_lo[a]) && (s_org[a] <= box_hi[a]);

    always_ff @(posedge clk) begin
      p1_rec[a]  <= rec;
      p1_din[a]  <= swap ? dhi : dlo;
      p1_dout[a] <= swap ? dlo : dhi;
      p1_skip[a] <= side_q[NS-1].dzero[a];
      // parallel axis misses when the origin is outside the slab
      p1_okax[a] <= !side_q[NS-1].dzero[a] || inslab;
    end

    always_ff @(posedge clk) begin
      p2_pin[a]  <= p1_din[a] * p1_rec[a];
      p2_pout[a] <= p1_dout[a] * p1_rec[a];
      p2_skip[a] <= p1_skip[a];
      p2_okax[a] <= p1_okax[a];
    end

    // arithmetic shift is the floor
    assign sh_in  = p2_pin[a] >>> FRAC_BITS;
    assign sh_out = p2_pout[a] >>> FRAC_BITS;

    always_ff @(posedge clk) begin
      p3_tin[a]  <= (sh_in > 65'(S32_MAX)) ? S32_MAX :
                    (sh_in < 65'(S32_MIN)) ? S32_MIN : DATA_W'(sh_in);
      p3_tout[a] <= (sh_out > 65'(S32_MAX)) ? S32_MAX :
                    (sh_out < 65'(S32_MIN)) ? S32_MIN : DATA_W'(sh_out);
      p3_skip[a] <= p2_skip[a];
      p3_okax[a] <= p2_okax[a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
    end else begin
      p1_vld <= dv_q[NS-1];
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
    end
  end

  // combine: near is the largest entry, far the smallest exit
  logic signed [DATA_W-1:0] near_v;
  logic signed [DATA_W-1:0] far_v;
  logic                     ok;

  always_comb begin
    near_v = S32_MIN;
    far_v  = S32_MAX;
    for (int a = 0; a < 3; a++) begin
      if (!p3_skip[a] && (p3_tin[a] > near_v)) begin
        near_v = p3_tin[a];
      end
      if (!p3_skip[a] && (p3_tout[a] < far_v)) begin
        far_v = p3_tout[a];
      end
    end
    ok = (&p3_okax) && !(near_v > far_v) && !far_v[DATA_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p3_vld;
    end
  end

  always_ff @(posedge clk) begin
    rsp.hit           <= ok;
    rsp.near_distance <= ok ? near_v : '0;
  end

endmodule

// ----- rtl/raabb_check.sv -----
module raabb_check
  import raabb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t rsp
);

  localparam int LAT = 2 * FRAC_BITS + 6;

  // every result strobe traces back to an accepted request
  a_done_has_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result strobe without a request");

  // a miss carries a zero distance
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !rsp.hit) |-> (rsp.near_distance == '0))
    else $error("miss with nonzero distance");

  // reset flushes the pipeline
  a_reset_flush: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result strobe right after reset");

  // requests are never refused
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("request refused");

endmodule

bind ray_aabb_slab_test raabb_check #(
  .FRAC_BITS (FRAC_BITS)
) u_raabb_check (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

// ----- tb/tb_top.sv -----
module tb_top;
  import raabb_pkg::*;

  localparam int FRAC      = FRAC_BITS_DEF;
  localparam int LAT       = 2 * FRAC + 5;
  localparam int WDOG_MAX  = 4000;
  localparam int N_RANDOM  = 1130;
  localparam int N_PHASES  = 7;
  localparam int QUIET_TAIL = 150;
  localparam logic signed [DATA_W-1:0] ONE = 32'sh0001_0000;
  // indexes past the box map; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_7 = 3'd7;

  typedef struct {
    req_t ray;
    bit   typed;     // expected value written in by hand
    rsp_t want;
  } ray_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  req_t                 req = '0;
  logic                 done;
  rsp_t                 rsp;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_BOX_MIN_X;
  logic [DATA_W-1:0]    cfg_data = '0;

  // our copy of the box registers
  logic signed [DATA_W-1:0] box_lo [3];
  logic signed [DATA_W-1:0] box_hi [3];

  rsp_t     hit_queue [$];
  ray_row_t dir_rows [$];
  int       n_fail = 0;
  int       n_sent = 0;
  int       n_checked = 0;
  int       n_hits = 0;
  int       n_boxes = 0;
  int       idle_pct = 30;
  int       wdog = 0;

  ray_aabb_slab_test #(.FRAC_BITS(FRAC)) i_dut (
    .clk, .rst, .start, .busy, .req, .done, .rsp, .cfg_we, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp32(longint x);
    if (x > longint'(S32_MAX)) return longint'(S32_MAX);
    if (x < longint'(S32_MIN)) return longint'(S32_MIN);
    return x;
  endfunction

  // slab test against our box copy; exact 64-bit arithmetic
  function automatic rsp_t trace_ray(req_t r);
    longint o [3];
    longint d [3];
    longint lo, hi, recip, t_in, t_out;
    longint near_t, far_t;
    bit     ok;
    rsp_t   res;
    o = '{longint'(r.origin_x), longint'(r.origin_y), longint'(r.origin_z)};
    d = '{longint'(r.dir_x), longint'(r.dir_y), longint'(r.dir_z)};
    near_t = longint'(S32_MIN);
    far_t  = longint'(S32_MAX);
    ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      lo = longint'(box_lo[a]);
      hi = longint'(box_hi[a]);
      if (d[a] == 0) begin
        // parallel axis: only the slab containment matters
        if (o[a] < lo || o[a] > hi) ok = 1'b0;
      end else begin
        recip = clamp32((64'sd1 <<< (2 * FRAC)) / d[a]);
        // arithmetic shift is floor division by 2^FRAC
        if (recip >= 0) begin
          t_in  = clamp32(((lo - o[a]) * recip) >>> FRAC);
          t_out = clamp32(((hi - o[a]) * recip) >>> FRAC);
        end else begin
          t_in  = clamp32(((hi - o[a]) * recip) >>> FRAC);
          t_out = clamp32(((lo - o[a]) * recip) >>> FRAC);
        end
        if (t_in > near_t) near_t = t_in;
        if (t_out < far_t) far_t = t_out;
      end
    end
    if (near_t > far_t || far_t < 0) ok = 1'b0;
    res.hit = ok;
    res.near_distance = ok ? near_t[DATA_W-1:0] : '0;
    return res;
  endfunction

  // send one request; start stays high into the next call unless we idle
  task automatic send_ray(req_t r, bit typed, rsp_t want, bit may_idle);
    int gap;
    if (may_idle && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    hit_queue.push_back(typed ? want : trace_ray(r));
    n_sent++;
  endtask

  // wait until every result is back, then a latency's worth of quiet
  task automatic drain();
    start <= 1'b0;
    while (hit_queue.size() != 0) @(posedge clk);
    repeat (LAT + 2) @(posedge clk);
  endtask

  // write the whole box; junk index writes follow it and must be ignored
  task automatic load_box(logic signed [DATA_W-1:0] lo [3],
                          logic signed [DATA_W-1:0] hi [3]);
    cfg_idx_t idx [6];
    logic [DATA_W-1:0] val [6];
    idx = '{CFG_BOX_MIN_X, CFG_BOX_MIN_Y, CFG_BOX_MIN_Z,
            CFG_BOX_MAX_X, CFG_BOX_MAX_Y, CFG_BOX_MAX_Z};
    val = '{lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]};
    cfg_we <= 1'b1;
    for (int k = 0; k < 6; k++) begin
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
    end
    cfg_index <= CFG_UNUSED_6;
    cfg_data  <= $urandom;
    @(posedge clk);
    cfg_index <= CFG_UNUSED_7;
    cfg_data  <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
    box_lo = lo;
    box_hi = hi;
    n_boxes++;
  endtask

  function automatic req_t mk_ray(logic signed [DATA_W-1:0] ox, oy, oz, dx, dy, dz);
    req_t r;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    return r;
  endfunction

  // mostly rays aimed around the box, some pure noise
  function automatic req_t rand_ray();
    req_t r;
    longint ctr, span;
    logic signed [DATA_W-1:0] o [3];
    logic signed [DATA_W-1:0] d [3];
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      if (mode == 0) r.dir_y = '0;
      return r;
    end
    for (int a = 0; a < 3; a++) begin
      ctr  = (longint'(box_lo[a]) + longint'(box_hi[a])) >>> 1;
      span = longint'(box_hi[a]) - longint'(box_lo[a]);
      if (span < 0) span = -span;
      if (span < 64'sd65536) span = 64'sd65536;
      if (span > 64'sd1073741824) span = 64'sd1073741824;
      o[a] = DATA_W'(clamp32(ctr + (longint'($signed($urandom)) % (2 * span))));
      case ($urandom_range(0, 7))
        0:       d[a] = '0;
        1:       d[a] = $signed($urandom_range(0, 15)) - 8;
        default: d[a] = $signed($urandom_range(0, 2 * ONE)) - ONE;
      endcase
    end
    return mk_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
  endfunction

  // result side: no back-pressure, so every strobe is checked on its edge
  always @(posedge clk) begin
    if (rst) begin
      wdog <= 0;
    end else begin
      if (done) begin
        if (hit_queue.size() == 0) begin
          $display("%0t: result with nothing expected: hit=%0b near=%0d",
                   $time, rsp.hit, rsp.near_distance);
          n_fail++;
        end else begin
          automatic rsp_t want = hit_queue.pop_front();
          if (rsp.hit !== want.hit) begin
            $display("%0t: hit mismatch: expected %0b actual %0b",
                     $time, want.hit, rsp.hit);
            n_fail++;
          end
          if (rsp.near_distance !== want.near_distance) begin
            $display("%0t: near_distance mismatch: expected %0d actual %0d",
                     $time, want.near_distance, rsp.near_distance);
            n_fail++;
          end
          if (want.hit) n_hits++;
          n_checked++;
        end
      end
      // watchdog: nothing accepted and nothing returned
      if (done || (start && !busy)) begin
        wdog <= 0;
      end else if (wdog >= WDOG_MAX) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 hit_queue.size());
        $display("== FAIL ==");
        $finish;
      end else begin
        wdog <= wdog + 1;
      end
    end
  end

  initial begin
    logic signed [DATA_W-1:0] lo [3];
    logic signed [DATA_W-1:0] hi [3];
    rsp_t miss, r0;
    int per_phase;
    miss = '0;
    box_lo = '{3{'0}};
    box_hi = '{3{'0}};

    // directed rows, unit box [-1,1]^3 after the first
    // after reset the box is a point at zero: a still ray sitting on it hits
    r0.hit = 1'b1; r0.near_distance = S32_MIN;
    dir_rows.push_back('{mk_ray('0, '0, '0, '0, '0, '0), 1'b1, r0});
    // straight down x from -2: enters at 1.0
    r0.hit = 1'b1; r0.near_distance = ONE;
    dir_rows.push_back('{mk_ray(-2 * ONE, '0, '0, ONE, '0, '0), 1'b1, r0});
    // parallel to every axis, outside in x
    dir_rows.push_back('{mk_ray(2 * ONE, '0, '0, '0, '0, '0), 1'b1, miss});
    // parallel in y, outside the y slab
    dir_rows.push_back('{mk_ray(-2 * ONE, -2 * ONE, '0, ONE, '0, '0), 1'b1, miss});
    // pointing away from the box
    dir_rows.push_back('{mk_ray(-2 * ONE, '0, '0, -ONE, '0, '0), 1'b0, miss});
    // origin inside: negative near
    dir_rows.push_back('{mk_ray('0, '0, '0, ONE, ONE, ONE), 1'b0, miss});
    dir_rows.push_back('{mk_ray('0, '0, '0, -ONE, -ONE, -ONE), 1'b0, miss});
    // tiny directions: reciprocal saturates
    dir_rows.push_back('{mk_ray(-2 * ONE, '0, '0, 32'sd1, '0, '0), 1'b0, miss});
    dir_rows.push_back('{mk_ray(2 * ONE, '0, '0, -32'sd1, '0, '0), 1'b0, miss});
    // huge directions (reciprocal of +-2 LSB), then extreme origins with tiny directions
    dir_rows.push_back('{mk_ray(-2 * ONE, '0, '0, S32_MAX, '0, '0), 1'b0, miss});
    dir_rows.push_back('{mk_ray(2 * ONE, '0, '0, S32_MIN, '0, '0), 1'b0, miss});
    dir_rows.push_back('{mk_ray(S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX),
                         1'b0, miss});
    dir_rows.push_back('{mk_ray(S32_MAX, S32_MAX, S32_MAX, S32_MIN, S32_MIN, S32_MIN),
                         1'b0, miss});
    dir_rows.push_back('{mk_ray(S32_MIN, '0, '0, 32'sd1, '0, '0), 1'b0, miss});
    dir_rows.push_back('{mk_ray(S32_MAX, S32_MAX, S32_MAX, -32'sd1, -32'sd1, -32'sd1),
                         1'b0, miss});
    // diagonal hits and grazing an edge
    dir_rows.push_back('{mk_ray(-3 * ONE, -3 * ONE, -3 * ONE, ONE, ONE, ONE), 1'b0, miss});
    dir_rows.push_back('{mk_ray(-2 * ONE, -ONE, ONE, ONE, '0, '0), 1'b0, miss});
    dir_rows.push_back('{mk_ray(-2 * ONE, 2 * ONE, '0, ONE, -ONE, '0), 1'b0, miss});
    // on a face, parallel: still inside the slab; then just past a face: outside
    dir_rows.push_back('{mk_ray(ONE, -ONE, '0, '0, '0, ONE), 1'b0, miss});
    dir_rows.push_back('{mk_ray(32'sh0001_0001, '0, -5 * ONE, '0, '0, ONE), 1'b0, miss});
    dir_rows.push_back('{mk_ray(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F,
                                32'shF0F0_F0F0, 32'sh3333_3333, 32'shCCCC_CCCC),
                         1'b0, miss});

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_ray(dir_rows[0].ray, dir_rows[0].typed, dir_rows[0].want, 1'b0);
    drain();
    lo = '{-ONE, -ONE, -ONE};
    hi = '{ONE, ONE, ONE};
    load_box(lo, hi);
    for (int k = 1; k < dir_rows.size(); k++)
      send_ray(dir_rows[k].ray, dir_rows[k].typed, dir_rows[k].want, 1'b1);

    // random part: one box per phase, the extremes among them
    per_phase = N_RANDOM / N_PHASES;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin lo = '{-ONE, -ONE, -ONE}; hi = '{ONE, ONE, ONE}; end
        1: begin lo = '{3{S32_MIN}}; hi = '{3{S32_MAX}}; end
        // inverted box: min above max
        2: begin lo = '{ONE, 2 * ONE, '0}; hi = '{-ONE, -ONE, -ONE}; end
        3: begin lo = '{3{S32_MAX}}; hi = '{3{S32_MAX}}; end
        4: begin lo = '{3{S32_MIN}}; hi = '{3{S32_MIN}}; end
        default: begin
          for (int a = 0; a < 3; a++) begin
            lo[a] = $urandom;
            hi[a] = $urandom;
            if (ph == 5 && lo[a] > hi[a]) begin
              lo[a] = hi[a];
              hi[a] = $urandom_range(0, 32'h7fff_ffff);
            end
          end
        end
      endcase
      load_box(lo, hi);
      // some phases run without idling at all
      idle_pct = (ph % 3 == 1) ? 0 : $urandom_range(10, 50);
      for (int k = 0; k < per_phase; k++) begin
        // hold off once until the pipe has fully drained
        if (ph == 3 && k == per_phase / 2) drain();
        if (ph == N_PHASES - 1 && k >= per_phase - QUIET_TAIL) idle_pct = 0;
        send_ray(rand_ray(), 1'b0, miss, 1'b1);
      end
    end

    start <= 1'b0;
    while (hit_queue.size() != 0) @(posedge clk);
    repeat (LAT + 5) @(posedge clk);

    $display("rays sent %0d, results checked %0d, hits %0d", n_sent, n_checked, n_hits);
    $display("box settings %0d incl. full range, inverted and degenerate", n_boxes);
    if (n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
